// ===== hw/rtl/chs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash set package
// Field widths, command codes and status codes shared by the hash set files.
// ----------------------------------------------------------------------------
package chs_pkg;

   localparam int KEY_W    = 31;
   localparam int STATUS_W = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

// ===== hw/rtl/chs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash set channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface chs_req_if;
   import chs_pkg::*;

   logic             valid;
   logic             ready;
   logic             command;
   logic [KEY_W-1:0] key;

   modport source (output valid, output command, output key, input ready);
   modport sink (input valid, input command, input key, output ready);
endinterface

interface chs_rsp_if;
   import chs_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [KEY_W-1:0]    match_key;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output found, output match_key, output status, input ready);
   modport sink (input valid, input found, input match_key, input status, output ready);
endinterface

// ===== hw/rtl/chained_hash_set_sorted_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash set with sorted chains
// Keeps a set of 31-bit keys in buckets of ascending linked chains drawn from
// a fixed node pool. Each request item inserts a key or searches for one and
// gives exactly one response item.
//
// The request channel takes an item only while the sequencer is idle. The
// response channel carries found, match_key and status from an output
// register, so a new request item is taken while a response waits.
// A request reads its bucket head, then visits the chain nodes one by one;
// an insert that links behind an existing node then writes that node's link
// in ST_LINK. An insert refused because the pool is full goes straight to
// the response. When BUCKETS is not a power of two, the bucket is found by a
// reciprocal multiplication in ST_DIV and ST_REM. The chain walk through the
// node memory sets the rate. After reset the block clears the bucket heads,
// one per cycle, and takes no request item meanwhile. A stalled response
// holds the next result in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module chained_hash_set_sorted_core #(
   parameter int BUCKETS    = 16,
   parameter int POOL_NODES = 256
) (
   input logic       clock,
   input logic       reset,
   chs_req_if.sink   req_chan,
   chs_rsp_if.source rsp_chan
);
   import chs_pkg::*;

   localparam int   BIW  = $clog2(BUCKETS);
   localparam int   IW   = $clog2(POOL_NODES);
   localparam int   PW   = $clog2(POOL_NODES + 1);
   localparam bit   POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam logic [PW-1:0]  NIL       = PW'(POOL_NODES);
   localparam logic [BIW-1:0] LAST_BKT  = BIW'(BUCKETS - 1);
   localparam logic [BIW:0]   BKT_CMP   = (BIW + 1)'(BUCKETS);
   localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / BUCKETS);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_REM, ST_HEAD_WAIT, ST_HEAD_CHK, ST_NODE, ST_LINK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PW-1:0]    link;
   } node_type;

   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [BIW-1:0]      bucket_ff, bucket_in;
   logic [KEY_W-1:0]    quot_ff, quot_in;
   logic [PW-1:0]       visit_ff, visit_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [KEY_W-1:0]    cur_key_ff, cur_key_in;
   logic [IW-1:0]       fresh_ff, fresh_in;
   logic                at_head_ff, at_head_in;
   logic [PW-1:0]       nodes_used_ff, nodes_used_in;
   logic [BIW-1:0]      clr_ff, clr_in;
   logic                res_found_ff, res_found_in;
   logic [KEY_W-1:0]    res_key_ff, res_key_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [PW-1:0] head_mem [BUCKETS];
   logic [PW-1:0] head_q;
   logic          head_we;
   logic [BIW-1:0] head_wa;
   logic [PW-1:0] head_wd;

   node_type      node_mem [POOL_NODES];
   node_type      node_q;
   logic          node_we;
   logic [IW-1:0] node_wa;
   node_type      node_wd;
   logic [IW-1:0] node_ra;

   logic [2*KEY_W-1:0] div_prod;
   logic [BIW:0]       div_rem;
   logic               accept;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.found  = rsp_found_ff;
   assign rsp_chan.match_key = rsp_key_ff;
   assign rsp_chan.status = rsp_status_ff;

   // The quotient estimate is low by at most one, so the remainder is below
   // twice the bucket count and fits in the low bits.
   assign div_prod = (2*KEY_W)'(key_ff) * (2*KEY_W)'(RECIP);
   assign div_rem  = key_ff[BIW:0] - quot_ff[BIW:0] * BKT_CMP;

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_q <= head_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_q <= node_mem[node_ra];
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      quot_in       = quot_ff;
      visit_in      = visit_ff;
      cur_in        = cur_ff;
      cur_key_in    = cur_key_ff;
      fresh_in      = fresh_ff;
      at_head_in    = at_head_ff;
      nodes_used_in = nodes_used_ff;
      clr_in        = clr_ff;
      res_found_in  = res_found_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      head_we       = 1'b0;
      head_wa       = bucket_ff;
      head_wd       = NIL;
      node_we       = 1'b0;
      node_wa       = fresh_ff;
      node_wd       = '{key: key_ff, link: NIL};
      node_ra       = node_q.link[IW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_BKT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in       = req_chan.command;
               key_in       = req_chan.key;
               at_head_in   = 1'b1;
               res_found_in = 1'b0;
               res_key_in   = '0;
               res_status_in = STATUS_OK;
               if (req_chan.command == CMD_INSERT && nodes_used_ff == NIL) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_FIN;
               end else begin
                  if (req_chan.command == CMD_INSERT) begin
                     fresh_in      = nodes_used_ff[IW-1:0];
                     nodes_used_in = nodes_used_ff + 1'b1;
                  end
                  if (POW2) begin
                     bucket_in = req_chan.key[BIW-1:0];
                     state_in  = ST_HEAD_WAIT;
                  end else begin
                     state_in  = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            quot_in  = div_prod[2*KEY_W-1:KEY_W];
            state_in = ST_REM;
         end
         ST_REM: begin
            if (div_rem >= BKT_CMP) begin
               bucket_in = BIW'(div_rem - BKT_CMP);
            end else begin
               bucket_in = div_rem[BIW-1:0];
            end
            state_in = ST_HEAD_WAIT;
         end
         ST_HEAD_WAIT: begin
            state_in = ST_HEAD_CHK;
         end
         ST_HEAD_CHK: begin
            node_ra  = head_q[IW-1:0];
            visit_in = head_q;
            if (head_q == NIL) begin
               if (cmd_ff == CMD_INSERT) begin
                  node_we = 1'b1;
                  head_we = 1'b1;
                  head_wd = PW'(fresh_ff);
               end else begin
                  res_status_in = STATUS_MISS;
               end
               state_in = ST_FIN;
            end else begin
               state_in = ST_NODE;
            end
         end
         ST_NODE: begin
            visit_in = node_q.link;
            if (cmd_ff == CMD_SEARCH) begin
               if (node_q.key == key_ff) begin
                  res_found_in = 1'b1;
                  res_key_in   = key_ff;
                  state_in     = ST_FIN;
               end else if (node_q.link == NIL) begin
                  res_status_in = STATUS_MISS;
                  state_in      = ST_FIN;
               end
            end else if (node_q.key >= key_ff) begin
               node_we = 1'b1;
               node_wd = '{key: key_ff, link: visit_ff};
               if (at_head_ff) begin
                  head_we  = 1'b1;
                  head_wd  = PW'(fresh_ff);
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_LINK;
               end
            end else begin
               cur_in     = visit_ff[IW-1:0];
               cur_key_in = node_q.key;
               at_head_in = 1'b0;
               if (node_q.link == NIL) begin
                  node_we  = 1'b1;
                  state_in = ST_LINK;
               end
            end
         end
         ST_LINK: begin
            node_we  = 1'b1;
            node_wa  = cur_ff;
            node_wd  = '{key: cur_key_ff, link: PW'(fresh_ff)};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_key_in    = res_key_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         nodes_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         nodes_used_ff <= nodes_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      bucket_ff     <= bucket_in;
      quot_ff       <= quot_in;
      visit_ff      <= visit_in;
      cur_ff        <= cur_in;
      cur_key_ff    <= cur_key_in;
      fresh_ff      <= fresh_in;
      at_head_ff    <= at_head_in;
      res_found_ff  <= res_found_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
